// File: rtl/fcpr_pkg.sv
package fcpr_pkg;

   localparam int CMD_W    = 2;
   localparam int PAGE_W   = 6;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = PAGE_W + 1;

   // request commands (code 3 is a no-op)
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

   localparam logic MODE_FIFO  = 1'b0;
   localparam logic MODE_CLOCK = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic                capture;
      logic                push;
      logic                read;
      logic                rotate;
      logic                evict;
      logic                mark;
      logic                step;
      logic                finish;
      logic [STATUS_W-1:0] status;
      logic                load;
   } fcpr_ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             mode;
      logic             empty;
      logic             full;
      logic             chance;
      logic             match;
      logic             last;
   } fcpr_stat_type;

endpackage

// File: rtl/fcpr_if.sv
interface fcpr_req_if import fcpr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [PAGE_W-1:0] page;

   modport source (output valid, output command, output page, input ready);
   modport sink   (input valid, input command, input page, output ready);
endinterface

interface fcpr_rsp_if import fcpr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PAGE_W-1:0]   victim_page;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output victim_page, output status, input ready);
   modport sink   (input valid, input victim_page, input status, output ready);
endinterface

// File: rtl/fcpr_datapath.sv
module fcpr_datapath import fcpr_pkg::*; #(
   parameter int MAX_PAGES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  fcpr_ctl_type        ctl,
   output fcpr_stat_type       stat,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output logic [PAGE_W-1:0]   rsp_victim_page,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int SLOT_W  = $clog2(MAX_PAGES);
   localparam int COUNT_W = $clog2(MAX_PAGES + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_PAGES);
   localparam logic [SLOT_W:0]    DEPTH_EXT  = (SLOT_W + 1)'(MAX_PAGES);
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(MAX_PAGES - 1);

   logic [ENTRY_W-1:0]  ring_mem [MAX_PAGES];

   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic                mode_ff, mode_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [PAGE_W-1:0]   res_page_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [PAGE_W-1:0]   out_page_ff;
   logic [STATUS_W-1:0] out_status_ff;

   logic [SLOT_W:0]     scan_sum, tail_sum;
   logic [SLOT_W-1:0]   scan_slot, tail_slot, head_next;
   logic [PAGE_W-1:0]   rd_page;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   assign rd_page = rd_data_ff[ENTRY_W-1:1];

   // ring positions: head below depth, offset at most depth, so one subtract wraps
   always_comb begin
      scan_sum  = {1'b0, head_ff} + (SLOT_W + 1)'(idx_ff);
      tail_sum  = {1'b0, head_ff} + (SLOT_W + 1)'(count_ff);
      scan_slot = (scan_sum >= DEPTH_EXT) ? SLOT_W'(scan_sum - DEPTH_EXT) : scan_sum[SLOT_W-1:0];
      tail_slot = (tail_sum >= DEPTH_EXT) ? SLOT_W'(tail_sum - DEPTH_EXT) : tail_sum[SLOT_W-1:0];
      head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + SLOT_W'(1);
   end

   always_comb begin
      wr_en   = ctl.push | ctl.rotate | ctl.mark;
      wr_addr = ctl.mark ? scan_slot : tail_slot;
      if (ctl.push) begin
         wr_data = {page_ff, 1'b1};
      end else if (ctl.mark) begin
         wr_data = {rd_page, 1'b1};
      end else begin
         wr_data = {rd_page, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (ctl.read) begin
         rd_data_ff <= ring_mem[scan_slot];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      mode_in  = csr_wr_en ? csr_wr_data : mode_ff;
      if (ctl.capture) begin
         idx_in = '0;
      end else if (ctl.step) begin
         idx_in = idx_ff + COUNT_W'(1);
      end
      if (ctl.push) begin
         count_in = count_ff + COUNT_W'(1);
      end
      if (ctl.rotate) begin
         head_in = head_next;
      end
      if (ctl.evict) begin
         head_in  = head_next;
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         mode_ff  <= MODE_CLOCK;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         mode_ff  <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_command;
         page_ff <= req_page;
      end
      if (ctl.finish) begin
         res_status_ff <= ctl.status;
         res_page_ff   <= ctl.evict ? rd_page : '0;
      end
      if (ctl.load) begin
         out_page_ff   <= res_page_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign stat.cmd    = cmd_ff;
   assign stat.mode   = mode_ff;
   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff == FULL_COUNT);
   assign stat.chance = rd_data_ff[0];
   assign stat.match  = (rd_page == page_ff);
   assign stat.last   = ((idx_ff + COUNT_W'(1)) == count_ff);

   assign rsp_victim_page = out_page_ff;
   assign rsp_status      = out_status_ff;

endmodule

// File: rtl/fcpr_ctrl.sv
module fcpr_ctrl import fcpr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  fcpr_stat_type stat,
   output fcpr_ctl_type  ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (stat.cmd)
               CMD_PUSH: begin
                  ctl.finish = 1'b1;
                  if (stat.full) begin
                     ctl.status = ST_FULL;
                  end else begin
                     ctl.push   = 1'b1;
                     ctl.status = ST_OK;
                  end
                  state_in = S_DONE;
               end
               CMD_POP: begin
                  if (stat.empty) begin
                     ctl.finish = 1'b1;
                     ctl.status = ST_EMPTY;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               CMD_ACCESS: begin
                  if (stat.empty) begin
                     ctl.finish = 1'b1;
                     ctl.status = ST_MISS;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  ctl.finish = 1'b1;
                  ctl.status = ST_OK;
                  state_in   = S_DONE;
               end
            endcase
         end
         S_READ: begin
            ctl.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.cmd == CMD_POP) begin
               // second chance: clear the bit, requeue at the tail, look again
               if (stat.mode == MODE_CLOCK && stat.chance) begin
                  ctl.rotate = 1'b1;
                  state_in   = S_READ;
               end else begin
                  ctl.evict  = 1'b1;
                  ctl.finish = 1'b1;
                  ctl.status = ST_OK;
                  state_in   = S_DONE;
               end
            end else if (stat.match) begin
               ctl.mark   = 1'b1;
               ctl.finish = 1'b1;
               ctl.status = ST_OK;
               state_in   = S_DONE;
            end else if (stat.last) begin
               ctl.finish = 1'b1;
               ctl.status = ST_MISS;
               state_in   = S_DONE;
            end else begin
               ctl.step = 1'b1;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/fifo_clock_page_replacer_core.sv
// Channel   Dir  Handshake          Payload
// req_chan  in   valid/ready        command[1:0], page[5:0]
// rsp_chan  out  valid/ready        victim_page[5:0], status[1:0]
// csr       in   csr_wr_en (write)  csr_wr_data = policy_mode
//
// One request at a time. Push, no-op and a pop on an empty ring go from DECIDE
// to DONE; pop and access loop READ and CHECK on the ring memory's single
// registered read port; clock-mode pops requeue marked heads. Reset is
// synchronous and clears head, count, scan index, mode, state and rsp valid.
// A response waits in the output register while the next request is taken;
// that one stalls only if it finishes while rsp is still held.
module fifo_clock_page_replacer_core import fcpr_pkg::*; #(
   parameter int MAX_PAGES = 64
) (
   input  logic      clock,
   input  logic      reset,
   fcpr_req_if.sink   req_chan,
   fcpr_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   fcpr_ctl_type  ctl;
   fcpr_stat_type stat;

   fcpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   fcpr_datapath #(
      .MAX_PAGES (MAX_PAGES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_command     (req_chan.command),
      .req_page        (req_chan.page),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_victim_page (rsp_chan.victim_page),
      .rsp_status      (rsp_chan.status)
   );

endmodule

// File: rtl/fcpr_checker.sv
module fcpr_checker import fcpr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [PAGE_W-1:0]   rsp_victim_page,
   input logic [STATUS_W-1:0] rsp_status
);

   // requests taken but not yet answered
   logic [1:0] pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'((req_valid && req_ready) ? 1 : 0)
                       - 2'((rsp_valid && rsp_ready) ? 1 : 0);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_victim_page == '0)
      else $error("victim page set on a failed request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a request");

   a_two_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("third request taken");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fifo_clock_page_replacer_core fcpr_checker u_fcpr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_victim_page (rsp_chan.victim_page),
   .rsp_status      (rsp_chan.status)
);

// File: tb/fifo_clock_page_replacer_core_tb.sv
module fifo_clock_page_replacer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fcpr_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_PER_SEGMENT = 75;
   localparam logic [CMD_W-1:0] CMD_IDLE = 2'd3;

   typedef struct packed {
      logic [PAGE_W-1:0]   victim_page;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   class replacer_scoreboard;
      logic [PAGE_W-1:0] ring_page [RING_DEPTH];
      bit                ring_chance [RING_DEPTH];
      int                head;
      int                count;
      logic              mode;
      outcome_type       due_outcomes [$];
      int                mismatches;
      int                checked;
      int                evictions;
      int                status_seen [4];

      function new();
         head = 0;
         count = 0;
         mode = MODE_CLOCK;
         mismatches = 0;
         checked = 0;
         evictions = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int slot_at(int offset);
         return (head + offset) % RING_DEPTH;
      endfunction

      function int pending();
         return due_outcomes.size();
      endfunction

      function int resident();
         return count;
      endfunction

      function logic [PAGE_W-1:0] page_at(int offset);
         return ring_page[slot_at(offset)];
      endfunction

      function void set_mode(logic policy);
         mode = policy;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
         outcome_type outcome;
         int          s;
         int          t;
         int          laps;
         bit          found;
         outcome.victim_page = '0;
         outcome.status = ST_OK;
         case (cmd)
            CMD_PUSH: begin
               if (count >= RING_DEPTH) begin
                  outcome.status = ST_FULL;
               end else begin
                  t = slot_at(count);
                  ring_page[t] = page;
                  ring_chance[t] = 1'b1;
                  count++;
               end
            end
            CMD_POP: begin
               if (count == 0) begin
                  outcome.status = ST_EMPTY;
               end else begin
                  if (mode == MODE_CLOCK) begin
                     // second chance: requeue marked heads with the mark cleared
                     laps = 0;
                     while (laps <= count && ring_chance[slot_at(0)]) begin
                        s = slot_at(0);
                        t = slot_at(count);
                        ring_chance[s] = 1'b0;
                        ring_page[t] = ring_page[s];
                        ring_chance[t] = 1'b0;
                        head = slot_at(1);
                        laps++;
                     end
                  end
                  outcome.victim_page = ring_page[slot_at(0)];
                  head = slot_at(1);
                  count--;
                  evictions++;
               end
            end
            CMD_ACCESS: begin
               found = 1'b0;
               for (int i = 0; i < count && !found; i++) begin
                  if (ring_page[slot_at(i)] == page) begin
                     ring_chance[slot_at(i)] = 1'b1;
                     found = 1'b1;
                  end
               end
               outcome.status = found ? ST_OK : ST_MISS;
            end
            default: ;
         endcase
         due_outcomes.push_back(outcome);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_response(logic [PAGE_W-1:0] victim_page, logic [STATUS_W-1:0] status);
         outcome_type want;
         if (due_outcomes.size() == 0) begin
            report_mismatch($sformatf("response victim %0d status %0d with no request open",
                                      victim_page, status));
         end else begin
            want = due_outcomes.pop_front();
            checked++;
            status_seen[want.status]++;
            if (victim_page !== want.victim_page || status !== want.status) begin
               report_mismatch($sformatf(
                  "response %0d: victim %0d (want %0d), status %0d (want %0d)",
                  checked, victim_page, want.victim_page, status, want.status));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   fcpr_req_if req_if ();
   fcpr_rsp_if rsp_if ();

   replacer_scoreboard sb;
   int send_idle;
   int recv_idle;
   bit filling;
   int cycle_count;

   fifo_clock_page_replacer_core #(
      .MAX_PAGES(RING_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_response(rsp_if.victim_page, rsp_if.status);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[fifo_clock_page_replacer_core] ERROR");
      $finish;
   end

   // valid stays up after acceptance; the next call gaps or presents the next request
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.page <= page;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(cmd, page);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_policy(logic policy);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= policy;
      @(posedge clock);
      sb.set_mode(policy);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // fill towards full, then drain towards empty, with accesses and no-ops mixed in
   task automatic random_request();
      int                roll;
      int                n;
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      n = sb.resident();
      if (n == RING_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (n == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 4) cmd = CMD_IDLE;
      else if (roll < 30) cmd = CMD_ACCESS;
      else if (roll < (filling ? 92 : 38)) cmd = CMD_PUSH;
      else cmd = CMD_POP;
      // a narrow pool gives duplicate pages
      if ($urandom_range(0, 1) == 0) page = PAGE_W'($urandom_range(0, 7));
      else page = PAGE_W'($urandom_range(0, 63));
      if (cmd == CMD_ACCESS && n > 0 && $urandom_range(0, 9) < 7) begin
         page = sb.page_at($urandom_range(0, n - 1));
      end
      send_request(cmd, page);
   endtask

   initial begin
      int phase;
      int half;
      int k;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_PUSH;
      req_if.page = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      sb = new();
      send_idle = 36;
      recv_idle = 64;
      filling = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // clock mode after reset
      send_request(CMD_POP, 6'd0);
      send_request(CMD_ACCESS, 6'd5);
      send_request(CMD_IDLE, 6'd63);
      send_request(CMD_PUSH, 6'd0);
      send_request(CMD_PUSH, 6'd63);
      send_request(CMD_PUSH, 6'd63);
      send_request(CMD_PUSH, 6'd42);
      send_request(CMD_ACCESS, 6'd63);
      send_request(CMD_ACCESS, 6'd17);
      // every entry marked: one full lap before the eviction
      send_request(CMD_POP, 6'd63);
      send_request(CMD_ACCESS, 6'd42);
      send_request(CMD_POP, 6'd0);

      write_policy(MODE_FIFO);
      send_request(CMD_PUSH, 6'd21);
      send_request(CMD_ACCESS, 6'd63);
      send_request(CMD_POP, 6'd0);
      send_request(CMD_POP, 6'd0);
      send_request(CMD_POP, 6'd0);
      send_request(CMD_POP, 6'd0);
      send_request(CMD_ACCESS, 6'd21);

      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 36 : (phase == 1) ? 64 : 0;
         recv_idle = (phase == 0) ? 64 : (phase == 1) ? 36 : 0;
         for (half = 0; half < 2; half++) begin
            write_policy(((phase + half) % 2 == 0) ? MODE_FIFO : MODE_CLOCK);
            for (k = 0; k < RANDOM_PER_SEGMENT; k++) begin
               if ($urandom_range(0, 49) == 0) wait_drained();
               random_request();
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("summary: %0d requests checked, %0d evictions, %0d empty pops, %0d full pushes",
               sb.checked, sb.evictions, sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
      $display("summary: %0d access misses; FIFO and clock eviction under %s",
               sb.status_seen[ST_MISS],
               "sender-heavy, receiver-heavy and free-flowing handshakes");
      if (sb.mismatches == 0) begin
         $display("[fifo_clock_page_replacer_core] OK");
      end else begin
         $display("[fifo_clock_page_replacer_core] ERROR");
      end
      $finish;
   end

endmodule
